### hdl/anseq_pkg.sv
package anseq_pkg;

	localparam int SCRIPT_DEPTH = 256;
	localparam int NEST_LIMIT   = 16;
	localparam int STEP_LIMIT   = 1024;
	localparam int FRAME_COST   = 100;

	localparam int AW  = $clog2(SCRIPT_DEPTH);
	localparam int NW  = $clog2(NEST_LIMIT);
	localparam int NDW = $clog2(NEST_LIMIT + 1);
	localparam int VW  = $clog2(STEP_LIMIT + 1);
	localparam int BW  = 16;

	typedef enum logic [2:0] {
		CMD_LOAD    = 3'd0,
		CMD_START   = 3'd1,
		CMD_TICK    = 3'd2,
		CMD_THROUGH = 3'd3,
		CMD_ARM     = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		OP_END  = 2'd0,
		OP_DRAW = 2'd1,
		OP_LOOP = 2'd2,
		OP_REP  = 2'd3
	} op_t;

	localparam logic [1:0] REP_IDLE    = 2'd0;
	localparam logic [1:0] REP_ARMED   = 2'd1;
	localparam logic [1:0] REP_REACHED = 2'd2;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  entry_index;
		op_t         opcode;
		logic [6:0]  arg_a;
		logic [15:0] duration;
		logic [7:0]  event_code;
		logic [14:0] advance;
		logic        end_hold;
		logic [7:0]  loop_total;
	} req_t;

	typedef struct packed {
		logic [6:0]  frame_chip;
		logic [7:0]  step_position;
		logic [15:0] frame_count;
		logic        playing;
		logic [7:0]  raised_event;
		logic [1:0]  repeat_status;
		logic        fault;
	} rsp_t;

	typedef struct packed {
		op_t         opcode;
		logic [6:0]  arg;
		logic [15:0] dur;
		logic [7:0]  evt;
	} entry_t;

	typedef struct packed {
		logic accept;
		logic fetch;
		logic exec;
		logic scan_rd;
		logic scan_ev;
		logic emit;
	} ctl_t;

	typedef struct packed {
		logic run;
		logic walk;
		logic over;
		logic need_scan;
		logic scan_done;
	} st_t;

endpackage

### hdl/anseq_ctrl.sv
module anseq_ctrl import anseq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	input  st_t  st,
	output ctl_t ctl,
	output logic busy,
	output logic strobe
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_FETCH   = 7'b0000010,
		S_EXEC    = 7'b0000100,
		S_SCAN_RD = 7'b0001000,
		S_SCAN_EV = 7'b0010000,
		S_OUT_RD  = 7'b0100000,
		S_OUT     = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req.cmd == CMD_TICK && st.run) state_d = S_FETCH;
					else state_d = S_OUT_RD;
				end
			end
			S_FETCH: begin
				if (!st.walk || st.over) state_d = S_OUT_RD;
				else state_d = S_EXEC;
			end
			S_EXEC: begin
				if (st.need_scan) state_d = S_SCAN_RD;
				else state_d = S_FETCH;
			end
			S_SCAN_RD: state_d = S_SCAN_EV;
			S_SCAN_EV: begin
				if (st.scan_done) state_d = S_FETCH;
				else state_d = S_SCAN_RD;
			end
			S_OUT_RD: state_d = S_OUT;
			S_OUT:    state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy        = (state_q != S_IDLE);
	assign strobe      = (state_q == S_OUT);
	assign ctl.accept  = start && (state_q == S_IDLE);
	assign ctl.fetch   = (state_q == S_FETCH);
	assign ctl.exec    = (state_q == S_EXEC);
	assign ctl.scan_rd = (state_q == S_SCAN_RD);
	assign ctl.scan_ev = (state_q == S_SCAN_EV);
	assign ctl.emit    = (state_q == S_OUT);

endmodule

### hdl/anseq_dp.sv
module anseq_dp import anseq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  ctl_t ctl,
	output st_t  st,
	output rsp_t rsp
);

	entry_t mem [SCRIPT_DEPTH];
	entry_t rda_q, rdb_q;

	logic [AW-1:0]       step_q, scan_q, addr_a, step_nx;
	logic                scan_loop_q;
	logic [15:0]         hold_q;
	logic signed [BW-1:0] budget_q;
	logic [NDW-1:0]      depth_q;
	logic [7:0]          counts_q [NEST_LIMIT];
	logic [7:0]          passes_q;
	logic                hold_mode_q, run_q, thru_q, fault_q;
	logic [1:0]          rep_q;
	logic [7:0]          evt_q;
	logic [VW-1:0]       visits_q;

	logic [16:0]         cnt1, cnt2;
	logic [NW-1:0]       top, push;
	logic [7:0]          topc;
	logic                found, need_scan;

	assign step_nx = (32'(step_q) == SCRIPT_DEPTH - 1) ? '0 : AW'(step_q + 1'b1);
	assign addr_a  = ctl.scan_rd ? scan_q : step_q;
	assign cnt1    = {1'b0, hold_q} + 17'd1;
	assign cnt2    = cnt1 + 17'd1;
	assign top     = NW'(depth_q - 1'b1);
	assign push    = depth_q[NW-1:0];
	assign topc    = counts_q[top];
	assign found   = scan_loop_q ? (rda_q.opcode == OP_LOOP) : (rda_q.opcode == OP_DRAW);

	assign need_scan = (step_q != '0) && (
		(rda_q.opcode == OP_END && passes_q == 8'd1 && hold_mode_q) ||
		(rda_q.opcode == OP_REP && depth_q != '0 && !thru_q && topc != 8'd1));

	assign st.run       = run_q;
	assign st.walk      = (budget_q > 0);
	assign st.over      = (32'(visits_q) >= STEP_LIMIT);
	assign st.need_scan = need_scan;
	assign st.scan_done = found || (scan_q == '0);

	always_ff @(posedge clk) begin
		if (ctl.accept && req.cmd == CMD_LOAD && 32'(req.entry_index) < SCRIPT_DEPTH) begin
			mem[AW'(req.entry_index)] <= {req.opcode, req.arg_a, req.duration, req.event_code};
		end
		rda_q <= mem[addr_a];
		rdb_q <= mem[step_nx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			scan_q      <= '0;
			scan_loop_q <= 1'b0;
			hold_q      <= '0;
			budget_q    <= '0;
			depth_q     <= '0;
			for (int i = 0; i < NEST_LIMIT; i++) counts_q[i] <= '0;
			passes_q    <= '0;
			hold_mode_q <= 1'b0;
			run_q       <= 1'b0;
			thru_q      <= 1'b0;
			fault_q     <= 1'b0;
			rep_q       <= REP_IDLE;
			evt_q       <= '0;
			visits_q    <= '0;
		end else begin
			if (ctl.accept) begin
				case (req.cmd)
					CMD_START: begin
						step_q      <= '0;
						hold_q      <= '0;
						budget_q    <= '0;
						depth_q     <= '0;
						for (int i = 0; i < NEST_LIMIT; i++) counts_q[i] <= '0;
						passes_q    <= req.loop_total;
						hold_mode_q <= req.end_hold;
						run_q       <= 1'b1;
						thru_q      <= 1'b0;
						rep_q       <= REP_IDLE;
						evt_q       <= '0;
						fault_q     <= 1'b0;
					end
					CMD_TICK: begin
						if (run_q) begin
							budget_q <= BW'(budget_q + $signed({1'b0, req.advance}));
							visits_q <= '0;
						end
					end
					CMD_THROUGH: thru_q <= 1'b1;
					CMD_ARM:     rep_q <= REP_ARMED;
					default: ;
				endcase
			end
			if (ctl.fetch && st.walk) begin
				if (st.over) begin
					fault_q  <= 1'b1;
					run_q    <= 1'b0;
					budget_q <= '0;
				end else begin
					visits_q <= VW'(visits_q + 1'b1);
				end
			end
			if (ctl.exec) begin
				case (rda_q.opcode)
					OP_END: begin
						if (step_q == '0 && !(passes_q == 8'd1 && !hold_mode_q))
							budget_q <= BW'(budget_q - BW'(FRAME_COST));
						if (passes_q == 8'd0) begin
							step_q <= '0;
						end else if (passes_q == 8'd1) begin
							run_q <= 1'b0;
							if (hold_mode_q) begin
								hold_q      <= '0;
								scan_q      <= AW'(step_q - 1'b1);
								scan_loop_q <= 1'b0;
							end else begin
								budget_q <= '0;
							end
						end else begin
							passes_q <= 8'(passes_q - 1'b1);
							step_q   <= '0;
						end
					end
					OP_DRAW: begin
						if (cnt1 > {1'b0, rda_q.dur}) begin
							step_q <= step_nx;
							hold_q <= '0;
						end else begin
							hold_q <= cnt1[15:0];
							if (cnt1 == 17'd1 && rda_q.evt != '0) evt_q <= rda_q.evt;
							if (rep_q == REP_ARMED && cnt2 > {1'b0, rda_q.dur}
								&& rdb_q.opcode == OP_REP) rep_q <= REP_REACHED;
							budget_q <= BW'(budget_q - BW'(FRAME_COST));
						end
					end
					OP_LOOP: begin
						if (32'(depth_q) >= NEST_LIMIT) begin
							fault_q  <= 1'b1;
							run_q    <= 1'b0;
							budget_q <= '0;
						end else begin
							counts_q[push] <= (rda_q.arg != '0) ? 8'(rda_q.arg + 1'b1) : 8'd0;
							depth_q        <= NDW'(depth_q + 1'b1);
							step_q         <= step_nx;
						end
					end
					default: begin
						if (depth_q == '0) begin
							step_q <= step_nx;
						end else if (thru_q || topc == 8'd1) begin
							thru_q         <= 1'b0;
							counts_q[top]  <= '0;
							depth_q        <= NDW'(depth_q - 1'b1);
							step_q         <= step_nx;
						end else begin
							if (topc != 8'd0) counts_q[top] <= 8'(topc - 1'b1);
							scan_q      <= AW'(step_q - 1'b1);
							scan_loop_q <= 1'b1;
						end
					end
				endcase
			end
			if (ctl.scan_ev) begin
				if (found || scan_q == '0) begin
					if (!scan_loop_q) step_q <= scan_q;
					else if (found) step_q <= AW'(scan_q + 1'b1);
					else step_q <= '0;
				end else begin
					scan_q <= AW'(scan_q - 1'b1);
				end
			end
			if (ctl.emit) evt_q <= '0;
		end
	end

	assign rsp.frame_chip    = rda_q.arg;
	assign rsp.step_position = 8'(step_q);
	assign rsp.frame_count   = hold_q;
	assign rsp.playing       = run_q;
	assign rsp.raised_event  = evt_q;
	assign rsp.repeat_status = rep_q;
	assign rsp.fault         = fault_q;

endmodule

### hdl/animation_script_sequencer.sv
// channel   direction  signals
// request   in         start, busy, req
// result    out        strobe, rsp
//
// A request is taken when start is high and busy is low.
// A request other than a tick while playing holds busy through S_OUT_RD and
// S_OUT; the result is on rsp in S_OUT, as it is for every request.
// A tick while playing holds busy in S_FETCH and S_EXEC per script entry
// visited, S_SCAN_RD and S_SCAN_EV per entry scanned back on a repeat jump or
// held end, then S_FETCH, S_OUT_RD and S_OUT. The registered script memory
// read sets this pace. busy goes low between requests, each ending in S_IDLE.
// Reset clears all play state; the script memory is undefined until loaded.
// strobe is high for one cycle per request; the receiver cannot stall it.
module animation_script_sequencer import anseq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic strobe,
	output rsp_t rsp
);

	ctl_t ctl;
	st_t  st;

	anseq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy),
		.strobe (strobe)
	);

	anseq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.st     (st),
		.rsp    (rsp)
	);

endmodule

### hdl/anseq_chk.sv
module anseq_chk import anseq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input rsp_t rsp
);

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request not taken");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result outside a request");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !busy && !strobe) else $error("result not followed by idle");

	a_rep_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> rsp.repeat_status != 2'd3) else $error("bad repeat status");

endmodule

bind animation_script_sequencer anseq_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.rsp    (rsp)
);

### dv/anseq_checker.sv
`timescale 1ns / 100ps

module anseq_checker import anseq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic strobe,
	input  rsp_t rsp,
	output int   errors,
	output int   pending,
	output int   results
);

	entry_t       script_mem [SCRIPT_DEPTH];
	int           step_pos;
	int           hold_cnt;
	int           budget;
	int           depth;
	int           loop_cnt [NEST_LIMIT];
	int           passes;
	bit           hold_end;
	bit           running;
	bit           through;
	logic [1:0]   rep_state;
	logic [7:0]   evt_latch;
	bit           faulted;
	rsp_t         status_q [$];

	function automatic void clear_play();
		step_pos  = 0;
		hold_cnt  = 0;
		budget    = 0;
		depth     = 0;
		foreach (loop_cnt[i]) loop_cnt[i] = 0;
		passes    = 0;
		hold_end  = 0;
		running   = 0;
		through   = 0;
		rep_state = REP_IDLE;
		evt_latch = '0;
		faulted   = 0;
	endfunction

	function automatic void trip();
		faulted = 1;
		running = 0;
		budget  = 0;
	endfunction

	function automatic void play_frames();
		int     visits;
		int     i;
		int     c;
		int     top;
		entry_t e;
		visits = 0;
		while (budget > 0) begin
			if (visits >= STEP_LIMIT) begin
				trip();
				return;
			end
			visits++;
			step_pos = step_pos % SCRIPT_DEPTH;
			e = script_mem[step_pos];
			case (e.opcode)
				OP_END: begin
					if (step_pos == 0) budget -= FRAME_COST;
					if (passes == 0) begin
						step_pos = 0;
					end else if (passes == 1) begin
						if (hold_end) begin
							i = step_pos;
							while (i > 0 && script_mem[i].opcode != OP_DRAW) i--;
							step_pos = i;
							running  = 0;
							hold_cnt = 0;
						end else begin
							running = 0;
							budget  = 0;
						end
					end else begin
						passes--;
						step_pos = 0;
					end
				end
				OP_DRAW: begin
					c = hold_cnt + 1;
					if (c > e.dur) begin
						step_pos = (step_pos + 1) % SCRIPT_DEPTH;
						hold_cnt = 0;
					end else begin
						hold_cnt = c;
						if (c == 1 && e.evt != 0) evt_latch = e.evt;
						if (rep_state == REP_ARMED && c + 1 > e.dur &&
							script_mem[(step_pos + 1) % SCRIPT_DEPTH].opcode == OP_REP)
							rep_state = REP_REACHED;
						budget -= FRAME_COST;
					end
				end
				OP_LOOP: begin
					if (depth >= NEST_LIMIT) begin
						trip();
						return;
					end
					loop_cnt[depth] = (e.arg != 0) ? (e.arg + 1) & 8'hff : 0;
					depth++;
					step_pos = (step_pos + 1) % SCRIPT_DEPTH;
				end
				default: begin
					if (depth == 0) begin
						step_pos = (step_pos + 1) % SCRIPT_DEPTH;
					end else begin
						top = depth - 1;
						if (through || loop_cnt[top] == 1) begin
							through = 0;
							loop_cnt[top] = 0;
							depth--;
							step_pos = (step_pos + 1) % SCRIPT_DEPTH;
						end else begin
							if (loop_cnt[top] != 0) loop_cnt[top]--;
							i = step_pos + 1;
							while (i > 0 && script_mem[i - 1].opcode != OP_LOOP) i--;
							step_pos = (i > 0) ? i % SCRIPT_DEPTH : 0;
						end
					end
				end
			endcase
		end
	endfunction

	function automatic rsp_t apply_request(req_t r);
		rsp_t s;
		case (r.cmd)
			CMD_LOAD: begin
				script_mem[r.entry_index].opcode = r.opcode;
				script_mem[r.entry_index].arg    = r.arg_a;
				script_mem[r.entry_index].dur    = r.duration;
				script_mem[r.entry_index].evt    = r.event_code;
			end
			CMD_START: begin
				clear_play();
				passes   = r.loop_total;
				hold_end = r.end_hold;
				running  = 1;
			end
			CMD_TICK: begin
				if (running) begin
					budget += r.advance;
					play_frames();
				end
			end
			CMD_THROUGH: through = 1;
			CMD_ARM:     rep_state = REP_ARMED;
			default: ;
		endcase
		step_pos = step_pos % SCRIPT_DEPTH;
		s.frame_chip    = script_mem[step_pos].arg;
		s.step_position = step_pos[7:0];
		s.frame_count   = hold_cnt[15:0];
		s.playing       = running;
		s.raised_event  = evt_latch;
		s.repeat_status = rep_state;
		s.fault         = faulted;
		evt_latch = '0;
		return s;
	endfunction

	initial begin
		clear_play();
		foreach (script_mem[i]) script_mem[i] = '0;
	end

	assign pending = status_q.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			clear_play();
			status_q.delete();
			errors  <= 0;
			results <= 0;
		end else begin
			if (start && !busy) status_q.push_back(apply_request(req));
			if (strobe) begin
				results <= results + 1;
				if (status_q.size() == 0) begin
					if (errors < 10) $display("ERROR: result with no request pending: %p", rsp);
					errors <= errors + 1;
				end else begin
					want = status_q.pop_front();
					if (rsp.frame_chip !== want.frame_chip ||
						rsp.step_position !== want.step_position ||
						rsp.frame_count !== want.frame_count ||
						rsp.playing !== want.playing ||
						rsp.raised_event !== want.raised_event ||
						rsp.repeat_status !== want.repeat_status ||
						rsp.fault !== want.fault) begin
						if (errors < 10)
							$display("ERROR: result mismatch\n  exp %p\n  got %p", want, rsp);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
	import anseq_pkg::*;

	localparam int STALL_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic strobe;
	rsp_t rsp;
	int   errors;
	int   pending;
	int   results;
	int   idle_pct;
	int   sent;
	int   quiet;
	int   runs;

	animation_script_sequencer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.strobe (strobe),
		.rsp    (rsp)
	);

	anseq_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.strobe  (strobe),
		.rsp     (rsp),
		.errors  (errors),
		.pending (pending),
		.results (results)
	);

	initial clk = 0;
	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic send(req_t r);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		req   <= r;
		do @(negedge clk); while (busy);
		@(posedge clk);
		sent++;
	endtask

	task automatic load(int idx, op_t op, int arg, int dur, int evt);
		req_t r;
		r = '0;
		r.cmd         = CMD_LOAD;
		r.entry_index = 8'(idx);
		r.opcode      = op;
		r.arg_a       = 7'(arg);
		r.duration    = 16'(dur);
		r.event_code  = 8'(evt);
		send(r);
	endtask

	task automatic order(cmd_t c, int adv = 0, int hold = 0, int total = 0);
		req_t r;
		r = '0;
		r.cmd        = c;
		r.advance    = 15'(adv);
		r.end_hold   = 1'(hold);
		r.loop_total = 8'(total);
		send(r);
	endtask

	task automatic noise();
		req_t r;
		r = req_t'({$urandom, $urandom, $urandom});
		if ($urandom_range(1)) begin
			r.cmd         = CMD_LOAD;
			r.entry_index = 8'($urandom_range(64, 255));
			r.arg_a       = 7'($urandom_range(126));
		end else begin
			r.cmd = cmd_t'(3'($urandom_range(5, 7)));
		end
		send(r);
	endtask

	task automatic script_run();
		int len;
		int k;
		int p;
		op_t op;
		len = $urandom_range(2, 12);
		for (int i = 0; i < len; i++) begin
			p = $urandom_range(99);
			op = (i == len - 1) ? OP_END : (p < 50) ? OP_DRAW : (p < 70) ? OP_LOOP :
				(p < 90) ? OP_REP : OP_END;
			p = $urandom_range(99);
			load(i, op,
				(op == OP_LOOP && p < 60) ? $urandom_range(1, 3) :
				(op == OP_LOOP && p < 80) ? 0 : $urandom_range(126),
				(p < 70) ? $urandom_range(4) : (p < 90) ? $urandom_range(5, 40) :
				$urandom_range(65535),
				$urandom_range(1) ? 0 : $urandom_range(255));
		end
		order(CMD_START, 0, $urandom_range(1),
			$urandom_range(9) ? $urandom_range(5) : $urandom_range(255));
		k = $urandom_range(3, 10);
		repeat (k) begin
			p = $urandom_range(99);
			if (p < 70)      order(CMD_TICK, $urandom_range(9) ? $urandom_range(800) :
				$urandom_range(32767));
			else if (p < 80) order(CMD_ARM);
			else if (p < 88) order(CMD_THROUGH);
			else if (p < 97) noise();
			else             order(CMD_START, 0, $urandom_range(1), $urandom_range(4));
		end
		runs++;
	endtask

	initial begin
		arst_n   = 0;
		start    = 0;
		req      = '0;
		sent     = 0;
		runs     = 0;
		idle_pct = 38;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		load(0, OP_DRAW, 126, 2, 255);
		load(1, OP_LOOP, 2, 0, 0);
		load(2, OP_DRAW, 1, 0, 0);
		load(3, OP_REP, 0, 0, 0);
		load(4, OP_DRAW, 5, 1, 7);
		load(5, OP_END, 0, 0, 0);
		load(255, OP_REP, 126, 65535, 255);
		order(CMD_START, 0, 1, 2);
		order(CMD_ARM);
		order(CMD_TICK, 350);
		order(CMD_THROUGH);
		order(CMD_TICK, 32767);
		order(CMD_TICK, 0);
		order(CMD_TICK, 500);
		noise();
		order(CMD_START, 0, 0, 0);
		order(CMD_TICK, 900);
		order(CMD_START, 0, 0, 1);
		order(CMD_TICK, 32767);
		load(0, OP_END, 0, 0, 0);
		order(CMD_START, 0, 0, 0);
		order(CMD_TICK, 32767);
		load(0, OP_LOOP, 0, 0, 0);
		load(1, OP_END, 0, 0, 0);
		order(CMD_TICK, 100);
		order(CMD_START, 0, 1, 255);
		order(CMD_TICK, 100);

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 38 : (ph == 1) ? 64 : 0;
			while (sent < 25 + (ph + 1) * 170) script_run();
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Ran %0d requests (%0d results) over %0d random scripts,", sent, results, runs);
		$display("with loops, repeats, held ends, runaway and nesting faults.");
		if (errors == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
